### design/plc_pkg.sv
// Package for the positional list store: action and error codes,
// cell command codes and the request/response payload structs.
// No dependencies.
`default_nettype none

package plc_pkg;

	localparam int ACT_W  = 3;
	localparam int POS_W  = 7;
	localparam int VAL_W  = 32;
	localparam int NLEN_W = 16;
	localparam int LEN_W  = 7;
	localparam int ERR_W  = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_READ      = 3'd0,
		ACT_APPEND    = 3'd1,
		ACT_INSERT    = 3'd2,
		ACT_DELETE    = 3'd3,
		ACT_OVERWRITE = 3'd4,
		ACT_SET_LEN   = 3'd5
	} act_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK   = 2'd0,
		ERR_POS  = 2'd1,
		ERR_FULL = 2'd2,
		ERR_LEN  = 2'd3
	} err_t;

	// What every cell in the row does on one edge.
	typedef enum logic [1:0] {
		CELL_HOLD = 2'd0,
		CELL_PUT  = 2'd1,
		CELL_INS  = 2'd2,
		CELL_DEL  = 2'd3
	} cell_op_t;

	typedef struct packed {
		err_t err;
		logic rd_ok;
	} plc_stat_t;

	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [POS_W-1:0]  position;
		logic [VAL_W-1:0]  value;
		logic [NLEN_W-1:0] new_length;
	} plc_req_t;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic [LEN_W-1:0] length;
		logic [ERR_W-1:0] error;
	} plc_rsp_t;

endpackage

`default_nettype wire

### design/plc_stream_if.sv
// Valid/ready stream channel carrying one payload of type T.
// No dependencies.
`default_nettype none

interface plc_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/plc_ctrl.sv
// Action decoder: checks position against the count and the new length against
// DEPTH, picks the cell command for the row and the next count. Depends on plc_pkg.
`default_nettype none

module plc_ctrl #(
	parameter int DEPTH = 64,
	parameter int CNT_W = 7
) (
	input  logic                     fire,
	input  logic [2:0]               action,
	input  logic [6:0]               position,
	input  logic [15:0]              new_length,
	input  logic [CNT_W-1:0]         count,
	output plc_pkg::cell_op_t        op,
	output logic [CNT_W-1:0]         lo,
	output logic [CNT_W-1:0]         hi,
	output logic [CNT_W-1:0]         next_count,
	output plc_pkg::plc_stat_t       stat
);
	import plc_pkg::*;

	localparam int CMP_W = ((CNT_W > NLEN_W) ? CNT_W : NLEN_W) + 1;

	logic [CMP_W-1:0] pos_w;
	logic [CMP_W-1:0] cnt_w;
	logic [CMP_W-1:0] nlen_w;
	logic [CMP_W-1:0] dep_w;
	logic             pos_in;
	logic             full;
	cell_op_t         op_d;

	assign pos_w  = CMP_W'(position);
	assign cnt_w  = CMP_W'(count);
	assign nlen_w = CMP_W'(new_length);
	assign dep_w  = CMP_W'(DEPTH);
	// count never exceeds DEPTH, so this also keeps the position in the row
	assign pos_in = pos_w < cnt_w;
	assign full   = cnt_w == dep_w;

	always_comb begin
		op_d       = CELL_HOLD;
		lo         = '0;
		hi         = '0;
		next_count = count;
		stat.err   = ERR_OK;
		stat.rd_ok = 1'b0;
		unique case (act_t'(action))
			ACT_READ: begin
				if (pos_in) stat.rd_ok = 1'b1;
				else        stat.err   = ERR_POS;
			end
			ACT_APPEND: begin
				if (full) begin
					stat.err = ERR_FULL;
				end else begin
					op_d       = CELL_PUT;
					lo         = count;
					hi         = CNT_W'(cnt_w + 1'b1);
					next_count = CNT_W'(cnt_w + 1'b1);
				end
			end
			ACT_INSERT: begin
				if (pos_w > cnt_w) begin
					stat.err = ERR_POS;
				end else if (full) begin
					stat.err = ERR_FULL;
				end else begin
					op_d       = CELL_INS;
					lo         = CNT_W'(pos_w);
					hi         = CNT_W'(cnt_w + 1'b1);
					next_count = CNT_W'(cnt_w + 1'b1);
				end
			end
			ACT_DELETE: begin
				if (!pos_in) begin
					stat.err = ERR_POS;
				end else begin
					// old top cell keeps its value
					op_d       = CELL_DEL;
					lo         = CNT_W'(pos_w);
					hi         = CNT_W'(cnt_w - 1'b1);
					next_count = CNT_W'(cnt_w - 1'b1);
				end
			end
			ACT_OVERWRITE: begin
				if (!pos_in) begin
					stat.err = ERR_POS;
				end else begin
					op_d = CELL_PUT;
					lo   = CNT_W'(pos_w);
					hi   = CNT_W'(pos_w + 1'b1);
				end
			end
			ACT_SET_LEN: begin
				if (nlen_w > dep_w) stat.err   = ERR_LEN;
				else                next_count = CNT_W'(nlen_w);
			end
			default: begin
			end
		endcase
	end

	assign op = fire ? op_d : CELL_HOLD;

endmodule

`default_nettype wire

### design/plc_cell.sv
// One storage cell of the row: holds an element, loads new data or takes
// its left or right neighbor when its index lies in [lo, hi). Depends on plc_pkg.
`default_nettype none

module plc_cell #(
	parameter int ELEM_WIDTH = 32,
	parameter int CNT_W      = 7,
	parameter int IDX        = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  plc_pkg::cell_op_t       op,
	input  logic [CNT_W-1:0]        lo,
	input  logic [CNT_W-1:0]        hi,
	input  logic [ELEM_WIDTH-1:0]   value,
	input  logic [ELEM_WIDTH-1:0]   left,
	input  logic [ELEM_WIDTH-1:0]   right,
	output logic [ELEM_WIDTH-1:0]   data
);
	import plc_pkg::*;

	localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

	logic                  in_rng;
	logic [ELEM_WIDTH-1:0] data_d;
	logic [ELEM_WIDTH-1:0] data_q;

	assign in_rng = (lo <= IDX_C) && (IDX_C < hi);

	always_comb begin
		data_d = data_q;
		case (op)
			CELL_PUT: if (in_rng) data_d = value;
			CELL_INS: if (in_rng) data_d = (IDX_C == lo) ? value : left;
			CELL_DEL: if (in_rng) data_d = right;
			default:  data_d = data_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) data_q <= '0;
		else         data_q <= data_d;
	end

	assign data = data_q;

endmodule

`default_nettype wire

### design/positional_list_store.sv
// Positional list store top level: decoder, row of cells, count and
// response register. Depends on plc_pkg, plc_stream_if, plc_ctrl, plc_cell.
//
//   channel | dir | payload                                   | transfer when
//   --------+-----+-------------------------------------------+---------------
//   req     | in  | action, position, value, new_length       | valid && ready
//   rsp     | out | read_value, length, error                 | valid && ready
//
// Every action finishes in the cycle of its transfer: the decoder drives one
// command across the whole row of cells, and each cell loads, shifts from a
// neighbor or holds on that same edge. One item per cycle, sustained while rsp is ready.
// A request is taken whenever the response register is empty or is being
// drained in the same cycle, so a stalled rsp stalls req by at most that register.
// Reset clears the count, every cell and the response register at once;
// no clearing pass follows reset.
`default_nettype none

module positional_list_store #(
	parameter int DEPTH      = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	plc_stream_if.sink    req,
	plc_stream_if.source  rsp
);
	import plc_pkg::*;

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int IDX_W = $clog2(DEPTH);

	logic                  fire;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      next_count;
	cell_op_t              op;
	logic [CNT_W-1:0]      lo;
	logic [CNT_W-1:0]      hi;
	plc_stat_t             stat;
	logic [ELEM_WIDTH-1:0] wr_value;
	logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
	logic [IDX_W-1:0]      rd_idx;
	logic [VAL_W-1:0]      rd_value;
	logic                  rsp_valid_q;
	plc_rsp_t              rsp_q;

	// Take a request while the response slot is free or draining.
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	// Keep only the low ELEM_WIDTH bits of incoming data.
	assign wr_value = ELEM_WIDTH'(req.data.value);

	plc_ctrl #(
		.DEPTH (DEPTH),
		.CNT_W (CNT_W)
	) u_ctrl (
		.fire       (fire),
		.action     (req.data.action),
		.position   (req.data.position),
		.new_length (req.data.new_length),
		.count      (count_q),
		.op         (op),
		.lo         (lo),
		.hi         (hi),
		.next_count (next_count),
		.stat       (stat)
	);

	// Row of cells: insert pulls from the left neighbor, delete from the right.
	// The end cells never take from past the row, so those inputs are tied off.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ELEM_WIDTH-1:0] left_d;
		logic [ELEM_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		plc_cell #(
			.ELEM_WIDTH (ELEM_WIDTH),
			.CNT_W      (CNT_W),
			.IDX        (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.op     (op),
			.lo     (lo),
			.hi     (hi),
			.value  (wr_value),
			.left   (left_d),
			.right  (right_d),
			.data   (cell_data[i])
		);
	end

	// Read port: select the addressed cell; drop the value unless the read is good.
	assign rd_idx   = IDX_W'(req.data.position);
	assign rd_value = stat.rd_ok ? VAL_W'(cell_data[rd_idx]) : '0;

	// Hold count and response; advance both on a request transfer, drop valid once drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= next_count;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_q <= '0;
		end else if (fire) begin
			rsp_q.read_value <= rd_value;
			rsp_q.length     <= LEN_W'(next_count);
			rsp_q.error      <= stat.err;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

`ifndef SYNTH
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("count above capacity");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> rsp_valid_q)
		else $error("transfer without response");

	a_len_match: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.length == LEN_W'(count_q))
		else $error("response length differs from count");

	a_full_code: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.error == ERR_FULL) |-> count_q == CNT_W'(DEPTH))
		else $error("full reported below capacity");
`endif

endmodule

`default_nettype wire
